>>> rtl/core/b64d_pkg.sv
// Shared types, status codes and the symbol decode table of the base64 decoder.
// No dependencies; every other rtl/core file imports this package.
package b64d_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_PAD  = 2'd2,
        ST_BAD_CHAR = 2'd3
    } status_t;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PAD   = 8'd61;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [1:0] status_code;
        logic       last;
    } res_t;

    // Results caused by one accepted character: up to three bytes, then status.
    typedef struct packed {
        logic [1:0]  byte_cnt;
        logic [23:0] bytes;
        logic        has_status;
        status_t     code;
    } bundle_t;

    // Map a character to {valid, sextet}.
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = {1'b1, 6'(c - 8'd65)};
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r = {1'b1, 6'(c - 8'd97 + 8'd26)};
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = {1'b1, 6'(c - 8'd48 + 8'd52)};
        end else if (c == 8'd43) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'd47) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/b64d_core.sv
// Group state and per-character decode step of the base64 decoder.
// Depends on b64d_pkg; feeds a result bundle to b64d_emit.
module b64d_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  b64d_pkg::char_t  item,
    output b64d_pkg::bundle_t bundle
);
    import b64d_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        twp_reg, twp_next;
    logic        pgs_reg, pgs_next;
    logic        gpe_reg, gpe_next;
    logic        gbc_reg, gbc_next;
    status_t     fe_reg, fe_next;

    logic        ws;
    logic        is_pad;
    logic [6:0]  sym;
    logic [5:0]  v;
    logic [23:0] triple;
    logic        padded;

    assign ws = (item.char_code == CH_LF) || (item.char_code == CH_CR) ||
                (item.char_code == CH_TAB) || (item.char_code == CH_SPACE);
    assign is_pad = (item.char_code == CH_PAD);
    assign sym = sym_decode(item.char_code);

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        twp_next = twp_reg;
        pgs_next = pgs_reg;
        gpe_next = gpe_reg;
        gbc_next = gbc_reg;
        fe_next  = fe_reg;
        v        = 6'd0;
        triple   = 24'd0;
        padded   = 1'b0;
        bundle   = '{byte_cnt: 2'd0, bytes: 24'd0, has_status: 1'b0, code: ST_OK};

        if (!ws)
        begin
            // a symbol after a padded group breaks the padding rule
            if (pgs_reg)
            begin
                if (fe_reg == ST_OK)
                begin
                    fe_next = ST_BAD_PAD;
                end
                pgs_next = 1'b0;
            end
            if (pos_reg == 2'd0)
            begin
                acc_next = 18'd0;
                twp_next = 1'b0;
                gpe_next = 1'b0;
                gbc_next = 1'b0;
            end
            if (is_pad)
            begin
                if (pos_reg < 2'd2)
                begin
                    gpe_next = 1'b1;
                end
                else if (pos_reg == 2'd2)
                begin
                    twp_next = 1'b1;
                end
            end
            else
            begin
                if (!sym[6])
                begin
                    gbc_next = 1'b1;
                end
                else
                begin
                    v = sym[5:0];
                end
                if (pos_reg == 2'd3 && twp_next)
                begin
                    gpe_next = 1'b1;
                end
            end

            if (pos_reg != 2'd3)
            begin
                acc_next = {acc_next[11:0], v};
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                triple   = {acc_next, v};
                padded   = twp_next || is_pad;
                pos_next = 2'd0;
                bundle.bytes = triple;
                if (fe_next == ST_OK)
                begin
                    if (gpe_next)
                    begin
                        fe_next = ST_BAD_PAD;
                    end
                    else if (padded)
                    begin
                        pgs_next = 1'b1;
                        if (!gbc_next)
                        begin
                            bundle.byte_cnt = twp_next ? 2'd1 : 2'd2;
                        end
                    end
                    else if (gbc_next)
                    begin
                        fe_next = ST_BAD_CHAR;
                    end
                    else
                    begin
                        bundle.byte_cnt = 2'd3;
                    end
                end
            end
        end

        if (item.end_of_text)
        begin
            bundle.has_status = 1'b1;
            if (pos_next != 2'd0)
            begin
                bundle.code = ST_BAD_LEN;
            end
            else if (fe_next != ST_OK)
            begin
                bundle.code = fe_next;
            end
            else if (pgs_next && gbc_next)
            begin
                bundle.code = ST_BAD_CHAR;
            end
            // close the stream: return to reset state
            acc_next = 18'd0;
            pos_next = 2'd0;
            twp_next = 1'b0;
            pgs_next = 1'b0;
            gpe_next = 1'b0;
            gbc_next = 1'b0;
            fe_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 18'd0;
            pos_reg <= 2'd0;
            twp_reg <= 1'b0;
            pgs_reg <= 1'b0;
            gpe_reg <= 1'b0;
            gbc_reg <= 1'b0;
            fe_reg  <= ST_OK;
        end
        else if (take)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            twp_reg <= twp_next;
            pgs_reg <= pgs_next;
            gpe_reg <= gpe_next;
            gbc_reg <= gbc_next;
            fe_reg  <= fe_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_text |=> pos_reg == 2'd0 && fe_reg == ST_OK && !pgs_reg)
        else $error("stream state not cleared after end of text");

    a_bytes_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        take && bundle.byte_cnt != 2'd0 |-> fe_reg == ST_OK && !pgs_reg)
        else $error("bytes emitted while an error is already known");

    a_ws_holds_group: assert property (@(posedge clk) disable iff (!rst_n)
        take && ws && !item.end_of_text |=> $stable(pos_reg) && $stable(acc_reg))
        else $error("whitespace changed group state");

endmodule

>>> rtl/core/b64d_emit.sv
// Result register and serializer: sends bytes of a bundle, then its status.
// Depends on b64d_pkg; loaded from b64d_core.
module b64d_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  b64d_pkg::bundle_t bundle,
    output logic              can_load,
    output logic              res_valid,
    input  logic              res_ready,
    output b64d_pkg::res_t    res_item
);
    import b64d_pkg::*;

    logic [23:0] bytes_reg, bytes_next;
    logic [1:0]  nbytes_reg, nbytes_next;
    logic        stat_reg, stat_next;
    status_t     code_reg, code_next;

    logic        out_fire;
    logic        final_one;

    assign res_valid = (nbytes_reg != 2'd0) || stat_reg;
    assign out_fire  = res_valid && res_ready;
    assign final_one = (nbytes_reg == 2'd1 && !stat_reg) || (nbytes_reg == 2'd0 && stat_reg);
    assign can_load  = !res_valid || (res_ready && final_one);

    always_comb
    begin
        if (nbytes_reg != 2'd0)
        begin
            res_item = '{is_status: 1'b0, data_byte: bytes_reg[23:16],
                         status_code: ST_OK, last: 1'b0};
        end
        else
        begin
            res_item = '{is_status: 1'b1, data_byte: 8'd0,
                         status_code: code_reg, last: 1'b1};
        end
    end

    always_comb
    begin
        bytes_next  = bytes_reg;
        nbytes_next = nbytes_reg;
        stat_next   = stat_reg;
        code_next   = code_reg;
        if (load)
        begin
            bytes_next  = bundle.bytes;
            nbytes_next = bundle.byte_cnt;
            stat_next   = bundle.has_status;
            code_next   = bundle.code;
        end
        else if (out_fire)
        begin
            // advance to the next byte, or drop the status once sent
            if (nbytes_reg != 2'd0)
            begin
                bytes_next  = {bytes_reg[15:0], 8'h00};
                nbytes_next = nbytes_reg - 2'd1;
            end
            else
            begin
                stat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbytes_reg <= 2'd0;
            stat_reg   <= 1'b0;
        end
        else
        begin
            nbytes_reg <= nbytes_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        code_reg  <= code_next;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !res_valid || (res_ready && final_one))
        else $error("bundle loaded over pending results");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.last |-> nbytes_reg == 2'd0 && res_item.is_status)
        else $error("status sent before its bytes");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && final_one && !load |=> !res_valid)
        else $error("result left after final transfer");

endmodule

>>> rtl/core/base64_decoder_checked.sv
// Streaming base64 decoder with end-of-text status; top level.
// Latency: a result appears the cycle after the character that causes it.
// Throughput: one character per cycle while each causes at most one result and
// res_ready is high; more hold input until the last is taken (result register).
// Reset: rst_n asynchronous active low clears group state and pending results.
// Depends on b64d_pkg, b64d_core and b64d_emit.
module base64_decoder_checked (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_ready,
    input  b64d_pkg::char_t  char_item,
    output logic             res_valid,
    input  logic             res_ready,
    output b64d_pkg::res_t   res_item
);
    import b64d_pkg::*;

    logic    can_load;
    logic    take;
    bundle_t bundle;

    assign char_ready = can_load;
    assign take       = char_valid && can_load;

    b64d_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (char_item),
        .bundle (bundle)
    );

    b64d_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .bundle    (bundle),
        .can_load  (can_load),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for base64_decoder_checked: directed streams, then random text.
// Results are predicted per accepted character and compared in order of arrival.
// Depends on b64d_pkg and the base64_decoder_checked top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    typedef logic [7:0] text_t[$];

    logic  clk;
    logic  rst_n;
    logic  char_valid;
    logic  char_ready;
    char_t char_item;
    logic  res_valid;
    logic  res_ready;
    res_t  res_item;

    base64_decoder_checked uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    // Decoder state mirrored by the predictor
    logic [17:0] sextets;
    logic [1:0]  grp_pos;
    logic        third_pad;
    logic        padded_seen;
    logic        grp_pad_err;
    logic        grp_bad;
    status_t     first_err;

    res_t  decoded_q[$];
    text_t text_buf;
    int    mismatches = 0;
    int    items_sent = 0;
    bit    tx_steady = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("base64_decoder_checked: mismatch");
        $finish;
    end

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE;
    endfunction

    // {valid, sextet}; sextet is zero for anything outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z")
            return {1'b1, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9")
            return {1'b1, 6'(c - "0" + 8'd52)};
        if (c == "+")
            return {1'b1, 6'd62};
        if (c == "/")
            return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    function automatic logic [7:0] char_of(input logic [5:0] v);
        if (v < 26)
            return "A" + v;
        if (v < 52)
            return "a" + v - 8'd26;
        if (v < 62)
            return "0" + v - 8'd52;
        return (v == 62) ? "+" : "/";
    endfunction

    function automatic res_t make_result(input logic st, input logic [7:0] b,
                                         input status_t code);
        res_t r;
        r.is_status   = st;
        r.data_byte   = b;
        r.status_code = code;
        r.last        = st;
        return r;
    endfunction

    function automatic void reset_decoder_state();
        sextets     = '0;
        grp_pos     = '0;
        third_pad   = 1'b0;
        padded_seen = 1'b0;
        grp_pad_err = 1'b0;
        grp_bad     = 1'b0;
        first_err   = ST_OK;
    endfunction

    function automatic void decode_char(input char_t it);
        logic [7:0]  c;
        logic [6:0]  sym;
        logic [5:0]  val;
        logic [23:0] triple;
        logic        pad;
        int          nbytes;
        status_t     code;
        c = it.char_code;
        if (!is_space(c))
        begin
            pad    = (c == CH_PAD);
            sym    = sextet_of(c);
            val    = pad ? 6'd0 : sym[5:0];
            nbytes = 0;
            // any symbol after a padded group breaks the padding rule
            if (padded_seen)
            begin
                if (first_err == ST_OK)
                    first_err = ST_BAD_PAD;
                padded_seen = 1'b0;
            end
            if (grp_pos == 2'd0)
            begin
                sextets     = '0;
                third_pad   = 1'b0;
                grp_pad_err = 1'b0;
                grp_bad     = 1'b0;
            end
            if (pad)
            begin
                if (grp_pos < 2)
                    grp_pad_err = 1'b1;
                else if (grp_pos == 2)
                    third_pad = 1'b1;
            end
            else
            begin
                if (!sym[6])
                    grp_bad = 1'b1;
                if (grp_pos == 2'd3 && third_pad)
                    grp_pad_err = 1'b1;
            end
            if (grp_pos != 2'd3)
            begin
                sextets = {sextets[11:0], val};
                grp_pos = grp_pos + 2'd1;
            end
            else
            begin
                triple  = {sextets, val};
                grp_pos = 2'd0;
                if (first_err == ST_OK)
                begin
                    if (grp_pad_err)
                        first_err = ST_BAD_PAD;
                    else if (third_pad || pad)
                    begin
                        padded_seen = 1'b1;
                        if (!grp_bad)
                            nbytes = third_pad ? 1 : 2;
                    end
                    else if (grp_bad)
                        first_err = ST_BAD_CHAR;
                    else
                        nbytes = 3;
                end
                for (int k = 0; k < nbytes; k++)
                    decoded_q.insert(decoded_q.size(),
                                     make_result(1'b0, triple[23 - 8 * k -: 8], ST_OK));
            end
        end
        if (it.end_of_text)
        begin
            if (grp_pos != 2'd0)
                code = ST_BAD_LEN;
            else if (first_err != ST_OK)
                code = first_err;
            else if (padded_seen && grp_bad)
                code = ST_BAD_CHAR;
            else
                code = ST_OK;
            decoded_q.insert(decoded_q.size(), make_result(1'b1, 8'd0, code));
            reset_decoder_state();
        end
    endfunction

    // Predict on every accepted character, compare every accepted result
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && char_valid && char_ready)
            decode_char(char_item);
        if (rst_n && res_valid && res_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: status=%0b byte=%h code=%0d last=%0b",
                             $time, res_item.is_status, res_item.data_byte,
                             res_item.status_code, res_item.last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (res_item.is_status !== want.is_status
                        || res_item.data_byte !== want.data_byte
                        || res_item.status_code !== want.status_code
                        || res_item.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected status=%0b byte=%h code=%0d last=%0b, got %0b %h %0d %0b",
                                 $time, want.is_status, want.data_byte, want.status_code,
                                 want.last, res_item.is_status, res_item.data_byte,
                                 res_item.status_code, res_item.last);
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Result side: random stalls, with stretches of steady ready
    initial
    begin
        int stall_left;
        int phase_left;
        bit rx_steady;
        stall_left = 0;
        phase_left = 0;
        rx_steady  = 1'b0;
        res_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase_left <= 0)
            begin
                rx_steady  = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready = 1'b1;
                if (!rx_steady)
                    stall_left = gap_len();
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        repeat (gap) @(negedge clk);
        char_item.char_code   = c;
        char_item.end_of_text = eot;
        char_valid            = 1'b1;
        do @(posedge clk); while (!char_ready);
        @(negedge clk);
        char_valid = 1'b0;
        items_sent++;
    endtask

    task automatic send_text(input text_t s);
        for (int i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
        send_text(text_buf);
    endtask

    task automatic wait_drained();
        while (decoded_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic push_symbol(input logic [7:0] c);
        if ($urandom_range(0, 11) == 0)
            text_buf.insert(text_buf.size(), pick_space());
        text_buf.insert(text_buf.size(), c);
    endtask

    // Encode nbytes random bytes; discarded low bits of padded groups stay random
    task automatic append_encoded(input int nbytes);
        logic [23:0] triple;
        int          rem;
        for (int i = 0; i < nbytes; i += 3)
        begin
            rem    = nbytes - i;
            triple = 24'($urandom);
            push_symbol(char_of(triple[23:18]));
            push_symbol(char_of(triple[17:12]));
            push_symbol(rem > 1 ? char_of(triple[11:6]) : CH_PAD);
            push_symbol(rem > 2 ? char_of(triple[5:0]) : CH_PAD);
        end
    endtask

    task automatic break_text();
        int idx;
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: text_buf[idx] = 8'($urandom_range(0, 255));
            1: text_buf.delete(idx);
            2: text_buf.insert(idx, CH_PAD);
            default:
            begin
                // padded group followed by more text
                text_buf.delete();
                append_encoded($urandom_range(1, 2));
                append_encoded($urandom_range(1, 6));
            end
        endcase
    endtask

    task automatic add_noise();
        int len;
        len = $urandom_range(0, 1) ? 4 * $urandom_range(1, 3) : $urandom_range(1, 10);
        repeat (len)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                4, 5:       text_buf.insert(text_buf.size(),
                                            char_of(6'($urandom_range(0, 63))));
                6:          text_buf.insert(text_buf.size(), CH_PAD);
                default:    text_buf.insert(text_buf.size(), pick_space());
            endcase
        end
    endtask

    task automatic test_valid_groups();
        send_string("Az+/");
        send_string("09Ma");
    endtask

    task automatic test_whitespace_only();
        text_buf.delete();
        text_buf.insert(text_buf.size(), CH_SPACE);
        text_buf.insert(text_buf.size(), CH_TAB);
        text_buf.insert(text_buf.size(), CH_CR);
        text_buf.insert(text_buf.size(), CH_LF);
        send_text(text_buf);
    endtask

    task automatic test_padding_rules();
        send_string("=AAA");     // padding early
        send_string("AB=C");     // lone pad in third place
        // hold off until the decoder has emptied
        wait_drained();
        send_string("Az==AAAA"); // padded group not last
    endtask

    task automatic test_invalid_chars();
        // extremes of the character range inside a padded last group
        text_buf.delete();
        text_buf.insert(text_buf.size(), 8'h00);
        text_buf.insert(text_buf.size(), 8'hFF);
        text_buf.insert(text_buf.size(), 8'd65);
        text_buf.insert(text_buf.size(), CH_PAD);
        send_text(text_buf);
    endtask

    task automatic test_bad_length();
        send_string("AB=");
    endtask

    task automatic test_random_streams();
        int kind;
        int streams;
        streams = 0;
        while (items_sent < 470)
        begin
            text_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 88)
            begin
                if ($urandom_range(0, 19) == 0)
                    append_encoded($urandom_range(13, 36));
                else
                    append_encoded($urandom_range(1, 9));
                if (kind >= 70)
                    break_text();
            end
            else
                add_noise();
            if ($urandom_range(0, 9) == 0 || text_buf.size() == 0)
                text_buf.insert(text_buf.size(), pick_space());
            tx_steady = ($urandom_range(0, 4) == 0);
            if (streams % 8 == 7)
                wait_drained();
            send_text(text_buf);
            streams++;
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_item  = '0;
        reset_decoder_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_valid_groups();
        test_whitespace_only();
        test_padding_rules();
        test_invalid_chars();
        test_bad_length();
        test_random_streams();

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("base64_decoder_checked: match");
        else
            $display("base64_decoder_checked: mismatch");
        $finish;
    end

endmodule

>>> base64_decoder_checked.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_core.sv
rtl/core/b64d_emit.sv
rtl/core/base64_decoder_checked.sv
bench/tb.sv
